@@ sv/assert_macros.svh @@
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable, expects clk and rst_n in scope
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons, msg) \
  `CHK_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define CHK_IMPLY_NEXT(lbl, ante, cons, msg) \
  `CHK_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ sv/spbs_pkg.sv @@
// shared types and constants of the sprite palette and box scanner
`default_nettype none
package spbs_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COORD_BITS_DEF    = 12;

  localparam int COLOR_W    = 32;
  localparam int SIZE_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_KEY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 2'd2;

  localparam logic [SIZE_W-1:0] SPRITE_SIZE_RST = 13'd16;

  // control flags of a request travelling down the palette chain
  typedef struct packed {
    logic valid;
    logic new_sheet;
    logic found;
    logic added;
  } tok_flags_t;

  // sprite flags carried alongside the chain
  typedef struct packed {
    logic first;
    logic last;
  } spr_flags_t;

endpackage
`default_nettype wire

@@ sv/sprite_palette_and_bbox_scanner_top.sv @@
// top level of the sprite palette and bounding box scanner
// a pixel passes the entry register, each palette cell and the result register
// unstalled throughput: one pixel per cycle, a request moves one cell per cycle
// a stalled result holds the whole chain and stalls the input in the same cycle
// reset (rst_n low, synchronous) empties the palette, zeroes the box and sets
// clip colour 0, sprite width and height 16; no clearing pass is needed
`default_nettype none
module sprite_palette_and_bbox_scanner_top #(
  parameter int PALETTE_DEPTH = spbs_pkg::PALETTE_DEPTH_DEF,
  parameter int COORD_BITS    = spbs_pkg::COORD_BITS_DEF,
  localparam int IW           = $clog2(PALETTE_DEPTH) + 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel requests
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [spbs_pkg::COLOR_W-1:0]       in_pixel_color,
  input  logic [COORD_BITS-1:0]              in_pos_x,
  input  logic [COORD_BITS-1:0]              in_pos_y,
  input  logic [COORD_BITS-1:0]              in_sprite_index,
  input  logic                               in_first_of_sprite,
  input  logic                               in_last_of_sprite,
  input  logic                               in_new_sheet,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [IW-1:0]                      out_palette_index,
  output logic                               out_color_is_new,
  output logic                               out_palette_full,
  output logic [IW-1:0]                      out_palette_size,
  output logic                               out_sprite_done,
  output logic [COORD_BITS:0]                out_box_x_min,
  output logic [COORD_BITS:0]                out_box_x_max,
  output logic [COORD_BITS:0]                out_box_y_min,
  output logic [COORD_BITS:0]                out_box_y_max,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // width of the sprite start column product
  localparam int PW = COORD_BITS + spbs_pkg::SIZE_W;

  // configuration registers
  logic [spbs_pkg::COLOR_W-1:0] clip_r;
  logic [spbs_pkg::SIZE_W-1:0]  width_r, height_r;

  // chain taps: stage k feeds cell k, stage PALETTE_DEPTH feeds the box unit
  spbs_pkg::tok_flags_t         flags_s [0:PALETTE_DEPTH];
  logic [spbs_pkg::COLOR_W-1:0] color_s [0:PALETTE_DEPTH];
  logic [IW-1:0]                index_s [0:PALETTE_DEPTH];
  logic [IW-1:0]                size_s  [0:PALETTE_DEPTH];

  // side line for box data, keeps step with the palette request
  spbs_pkg::spr_flags_t         spr_r   [0:PALETTE_DEPTH];
  logic [COORD_BITS-1:0]        px_r    [0:PALETTE_DEPTH];
  logic [COORD_BITS-1:0]        py_r    [0:PALETTE_DEPTH];
  logic [PW-1:0]                prod_r  [0:PALETTE_DEPTH];

  spbs_pkg::tok_flags_t         flags0_r;
  logic [spbs_pkg::COLOR_W-1:0] color0_r;
  logic                         en;

  // the whole chain moves unless a finished result is held by the sink
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r   <= '0;
      width_r  <= spbs_pkg::SPRITE_SIZE_RST;
      height_r <= spbs_pkg::SPRITE_SIZE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        spbs_pkg::CFG_CLIP_KEY:    clip_r   <= cfg_data[spbs_pkg::COLOR_W-1:0];
        spbs_pkg::CFG_CELL_WIDTH:  width_r  <= cfg_data[spbs_pkg::SIZE_W-1:0];
        spbs_pkg::CFG_CELL_HEIGHT: height_r <= cfg_data[spbs_pkg::SIZE_W-1:0];
        default: ; // unknown register, write dropped
      endcase
    end
  end

  // entry stage: request enters with nothing found yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags0_r <= '0;
    end else if (en) begin
      flags0_r.valid     <= in_valid;
      flags0_r.new_sheet <= in_new_sheet;
      flags0_r.found     <= 1'b0;
      flags0_r.added     <= 1'b0;
    end
  end

  // entry payload and box data, one tap per unstalled cycle beside the cells
  always_ff @(posedge clk) begin
    if (en) begin
      color0_r   <= in_pixel_color;
      spr_r[0]   <= '{first: in_first_of_sprite, last: in_last_of_sprite};
      px_r[0]    <= in_pos_x;
      py_r[0]    <= in_pos_y;
      // sprite start column, one multiply ahead of the box update
      prod_r[0]  <= PW'(in_sprite_index) * PW'(width_r);
      for (int k = 0; k < PALETTE_DEPTH; k++) begin
        spr_r[k+1]  <= spr_r[k];
        px_r[k+1]   <= px_r[k];
        py_r[k+1]   <= py_r[k];
        prod_r[k+1] <= prod_r[k];
      end
    end
  end

  // a request starts as not stored with an empty palette behind it
  assign flags_s[0] = flags0_r;
  assign color_s[0] = color0_r;
  assign index_s[0] = IW'(PALETTE_DEPTH);
  assign size_s[0]  = '0;

  // palette cells: a request matches the first equal entry or claims the
  // first empty one; a valid new-sheet request empties each cell as it passes
  for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
    spbs_cell #(
      .CELL_IDX (g),
      .IW       (IW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .flags_in  (flags_s[g]),
      .color_in  (color_s[g]),
      .index_in  (index_s[g]),
      .size_in   (size_s[g]),
      .flags_out (flags_s[g+1]),
      .color_out (color_s[g+1]),
      .index_out (index_s[g+1]),
      .size_out  (size_s[g+1])
    );
  end

  // box tracking and result register; not found at the end means palette full
  spbs_box #(
    .COORD_BITS (COORD_BITS),
    .IW         (IW),
    .PW         (PW)
  ) u_box (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .flags_in          (flags_s[PALETTE_DEPTH]),
    .spr_in            (spr_r[PALETTE_DEPTH]),
    .color_in          (color_s[PALETTE_DEPTH]),
    .index_in          (index_s[PALETTE_DEPTH]),
    .size_in           (size_s[PALETTE_DEPTH]),
    .px_in             (px_r[PALETTE_DEPTH]),
    .py_in             (py_r[PALETTE_DEPTH]),
    .prod_in           (prod_r[PALETTE_DEPTH]),
    .key_color         (clip_r),
    .cell_w            (width_r),
    .cell_h            (height_r),
    .out_valid         (out_valid),
    .out_palette_index (out_palette_index),
    .out_color_is_new  (out_color_is_new),
    .out_palette_full  (out_palette_full),
    .out_palette_size  (out_palette_size),
    .out_sprite_done   (out_sprite_done),
    .out_box_x_min     (out_box_x_min),
    .out_box_x_max     (out_box_x_max),
    .out_box_y_min     (out_box_y_min),
    .out_box_y_max     (out_box_y_max)
  );

endmodule
`default_nettype wire

@@ sv/spbs_cell.sv @@
// one palette cell: holds an entry, matches or claims it for a passing request
`default_nettype none
module spbs_cell #(
  parameter int CELL_IDX = 0,
  parameter int IW       = 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  spbs_pkg::tok_flags_t       flags_in,
  input  logic [spbs_pkg::COLOR_W-1:0] color_in,
  input  logic [IW-1:0]              index_in,
  input  logic [IW-1:0]              size_in,
  output spbs_pkg::tok_flags_t       flags_out,
  output logic [spbs_pkg::COLOR_W-1:0] color_out,
  output logic [IW-1:0]              index_out,
  output logic [IW-1:0]              size_out
);

  logic                         vld_r, vld_nxt, vld_eff;
  logic [spbs_pkg::COLOR_W-1:0] ent_r, ent_nxt;
  logic                         hit, claim;
  spbs_pkg::tok_flags_t         flags_r, flags_nxt;
  logic [spbs_pkg::COLOR_W-1:0] color_r;
  logic [IW-1:0]                index_r, index_nxt, size_r, size_nxt;

  always_comb begin
    // a new sheet empties the entry before the lookup
    vld_eff   = flags_in.new_sheet ? 1'b0 : vld_r;
    hit       = flags_in.valid && !flags_in.found && vld_eff && (ent_r == color_in);
    claim     = flags_in.valid && !flags_in.found && !vld_eff;
    vld_nxt   = flags_in.valid ? (vld_eff || claim) : vld_r;
    ent_nxt   = claim ? color_in : ent_r;
    flags_nxt = flags_in;
    flags_nxt.found = flags_in.found || hit || claim;
    flags_nxt.added = flags_in.added || claim;
    index_nxt = (hit || claim) ? IW'(CELL_IDX) : index_in;
    size_nxt  = (vld_eff || claim) ? IW'(CELL_IDX + 1) : size_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      flags_r <= '0;
    end else if (en) begin
      vld_r   <= vld_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r   <= ent_nxt;
      color_r <= color_in;
      index_r <= index_nxt;
      size_r  <= size_nxt;
    end
  end

  assign flags_out = flags_r;
  assign color_out = color_r;
  assign index_out = index_r;
  assign size_out  = size_r;

endmodule
`default_nettype wire

@@ sv/spbs_box.sv @@
// bounding box tracker and result register at the end of the chain
`default_nettype none
module spbs_box #(
  parameter int COORD_BITS = 12,
  parameter int IW         = 9,
  parameter int PW         = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  spbs_pkg::tok_flags_t          flags_in,
  input  spbs_pkg::spr_flags_t          spr_in,
  input  logic [spbs_pkg::COLOR_W-1:0]  color_in,
  input  logic [IW-1:0]                 index_in,
  input  logic [IW-1:0]                 size_in,
  input  logic [COORD_BITS-1:0]         px_in,
  input  logic [COORD_BITS-1:0]         py_in,
  input  logic [PW-1:0]                 prod_in,
  input  logic [spbs_pkg::COLOR_W-1:0]  key_color,
  input  logic [spbs_pkg::SIZE_W-1:0]   cell_w,
  input  logic [spbs_pkg::SIZE_W-1:0]   cell_h,
  output logic                          out_valid,
  output logic [IW-1:0]                 out_palette_index,
  output logic                          out_color_is_new,
  output logic                          out_palette_full,
  output logic [IW-1:0]                 out_palette_size,
  output logic                          out_sprite_done,
  output logic [COORD_BITS:0]           out_box_x_min,
  output logic [COORD_BITS:0]           out_box_x_max,
  output logic [COORD_BITS:0]           out_box_y_min,
  output logic [COORD_BITS:0]           out_box_y_max
);

  localparam logic [PW:0] LIMIT = (PW+1)'(1) << COORD_BITS;

  function automatic logic [COORD_BITS:0] sat(input logic [PW:0] v);
    sat = (v > LIMIT) ? LIMIT[COORD_BITS:0] : v[COORD_BITS:0];
  endfunction

  logic [COORD_BITS:0] xmin_r, xmax_r, ymin_r, ymax_r;
  logic [COORD_BITS:0] xmin_nxt, xmax_nxt, ymin_nxt, ymax_nxt;
  logic [COORD_BITS:0] xmin_s, xmax_s, ymin_s, ymax_s;
  logic [COORD_BITS:0] px_e, py_e;
  logic                nonclip;
  logic                valid_r;
  logic [IW-1:0]       index_r, size_r;
  logic                new_r, full_r, done_r;
  logic [COORD_BITS:0] bx0_r, bx1_r, by0_r, by1_r;

  always_comb begin
    px_e    = {1'b0, px_in};
    py_e    = {1'b0, py_in};
    nonclip = color_in != key_color;
    if (spr_in.first) begin
      xmin_s = sat({1'b0, prod_in} + (PW+1)'(cell_w));
      xmax_s = sat({1'b0, prod_in});
      ymin_s = sat((PW+1)'(cell_h));
      ymax_s = '0;
    end else begin
      xmin_s = xmin_r;
      xmax_s = xmax_r;
      ymin_s = ymin_r;
      ymax_s = ymax_r;
    end
    xmin_nxt = (nonclip && px_e < xmin_s) ? px_e : xmin_s;
    xmax_nxt = (nonclip && px_e > xmax_s) ? px_e : xmax_s;
    ymin_nxt = (nonclip && py_e < ymin_s) ? py_e : ymin_s;
    ymax_nxt = (nonclip && py_e > ymax_s) ? py_e : ymax_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r  <= '0;
      xmax_r  <= '0;
      ymin_r  <= '0;
      ymax_r  <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= flags_in.valid;
      if (flags_in.valid) begin
        xmin_r <= xmin_nxt;
        xmax_r <= xmax_nxt;
        ymin_r <= ymin_nxt;
        ymax_r <= ymax_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      index_r <= index_in;
      size_r  <= size_in;
      new_r   <= flags_in.added;
      full_r  <= !flags_in.found;
      done_r  <= spr_in.last;
      bx0_r   <= spr_in.last ? xmin_nxt : '0;
      bx1_r   <= spr_in.last ? xmax_nxt : '0;
      by0_r   <= spr_in.last ? ymin_nxt : '0;
      by1_r   <= spr_in.last ? ymax_nxt : '0;
    end
  end

  assign out_valid         = valid_r;
  assign out_palette_index = index_r;
  assign out_color_is_new  = new_r;
  assign out_palette_full  = full_r;
  assign out_palette_size  = size_r;
  assign out_sprite_done   = done_r;
  assign out_box_x_min     = bx0_r;
  assign out_box_x_max     = bx1_r;
  assign out_box_y_min     = by0_r;
  assign out_box_y_max     = by1_r;

endmodule
`default_nettype wire

@@ sv/spbs_checker.sv @@
// port-level checks for the scanner top, bound to it
`default_nettype none
`include "assert_macros.svh"
module spbs_checker #(
  parameter int PALETTE_DEPTH = spbs_pkg::PALETTE_DEPTH_DEF,
  parameter int COORD_BITS    = spbs_pkg::COORD_BITS_DEF,
  localparam int IW           = $clog2(PALETTE_DEPTH) + 1
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [IW-1:0]                   out_palette_index,
  input logic                            out_color_is_new,
  input logic                            out_palette_full,
  input logic [IW-1:0]                   out_palette_size,
  input logic                            out_sprite_done,
  input logic [COORD_BITS:0]             out_box_x_min,
  input logic [COORD_BITS:0]             out_box_x_max,
  input logic [COORD_BITS:0]             out_box_y_min,
  input logic [COORD_BITS:0]             out_box_y_max
);

  logic              out_held;
  logic [2*IW+1:0]   held_v;
  logic              box_zero;
  logic              full_shape;
  logic              new_at_end;

  assign out_held   = out_valid && out_stall;
  assign held_v     = {out_palette_index, out_color_is_new, out_palette_full, out_palette_size};
  assign box_zero   = out_box_x_min == '0 && out_box_x_max == '0 &&
                      out_box_y_min == '0 && out_box_y_max == '0;
  assign full_shape = out_palette_index == IW'(PALETTE_DEPTH) && !out_color_is_new &&
                      out_palette_size == IW'(PALETTE_DEPTH);
  assign new_at_end = (out_palette_index + IW'(1)) == out_palette_size && !out_palette_full;

  `CHK_IMPLY_NEXT(a_out_hold, out_held, out_valid && $stable(held_v), "held result moved")

  `CHK_IMPLY(a_box_zero, out_valid && !out_sprite_done, box_zero, "box set without sprite end")

  `CHK_IMPLY(a_full_index, out_valid && out_palette_full, full_shape, "bad drop result")

  `CHK_IMPLY(a_new_last, out_valid && out_color_is_new, new_at_end, "new colour not last")

  `CHK_ASSERT(a_stall_src, in_stall == out_held, "input stall without held result")

endmodule

bind sprite_palette_and_bbox_scanner_top spbs_checker #(
  .PALETTE_DEPTH (PALETTE_DEPTH),
  .COORD_BITS    (COORD_BITS)
) u_spbs_checker (.*);
`default_nettype wire

@@ dv/spbs_scan_checker.sv @@
`timescale 1ns / 1ps
// checker for the sprite palette and box scanner: predicts each result and compares it
module spbs_scan_checker #(
  parameter int  PAL_DEPTH = spbs_pkg::PALETTE_DEPTH_DEF,
  parameter int  CW        = spbs_pkg::COORD_BITS_DEF,
  localparam int IW        = $clog2(PAL_DEPTH) + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [spbs_pkg::COLOR_W-1:0]    in_pixel_color,
  input  logic [CW-1:0]                   in_pos_x,
  input  logic [CW-1:0]                   in_pos_y,
  input  logic [CW-1:0]                   in_sprite_index,
  input  logic                            in_first_of_sprite,
  input  logic                            in_last_of_sprite,
  input  logic                            in_new_sheet,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [IW-1:0]                   out_palette_index,
  input  logic                            out_color_is_new,
  input  logic                            out_palette_full,
  input  logic [IW-1:0]                   out_palette_size,
  input  logic                            out_sprite_done,
  input  logic [CW:0]                     out_box_x_min,
  input  logic [CW:0]                     out_box_x_max,
  input  logic [CW:0]                     out_box_y_min,
  input  logic [CW:0]                     out_box_y_max,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [spbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spbs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              n_pixels,
  output int                              n_boxes,
  output int                              n_dropped
);

  localparam logic [CW:0] BOX_LIMIT = (CW+1)'(1) << CW;

  typedef struct packed {
    logic [IW-1:0] index;
    logic          is_new;
    logic          full;
    logic [IW-1:0] size;
    logic          done;
    logic [CW:0]   x_min;
    logic [CW:0]   x_max;
    logic [CW:0]   y_min;
    logic [CW:0]   y_max;
  } scan_result_t;

  logic [spbs_pkg::COLOR_W-1:0] clip_colour;
  logic [spbs_pkg::SIZE_W-1:0]  spr_w;
  logic [spbs_pkg::SIZE_W-1:0]  spr_h;
  logic [spbs_pkg::COLOR_W-1:0] palette [PAL_DEPTH];
  int unsigned                  pal_count;
  logic [CW:0]                  box_x_lo, box_x_hi, box_y_lo, box_y_hi;
  scan_result_t                 scan_q [$];
  int                           n_results;

  initial begin
    fail_count = 0;
    pending    = 0;
    n_pixels   = 0;
    n_boxes    = 0;
    n_dropped  = 0;
    n_results  = 0;
  end

  function automatic logic [CW:0] sat_box(input longint unsigned v);
    return (v > longint'(BOX_LIMIT)) ? BOX_LIMIT : v[CW:0];
  endfunction

  function automatic scan_result_t scan_pixel(
    input logic [spbs_pkg::COLOR_W-1:0] colour,
    input logic [CW-1:0] px, py, sidx,
    input logic first, last, fresh
  );
    scan_result_t r;
    int unsigned  k;
    int unsigned  hit;
    bit           found;
    r     = '0;
    found = 1'b0;
    hit   = PAL_DEPTH;
    if (fresh) pal_count = 0;
    for (k = 0; k < pal_count; k++) begin
      if (!found && palette[k] == colour) begin
        found = 1'b1;
        hit   = k;
      end
    end
    if (!found) begin
      if (pal_count < PAL_DEPTH) begin
        palette[pal_count] = colour;
        hit                = pal_count;
        pal_count++;
        r.is_new = 1'b1;
      end else begin
        r.full = 1'b1;
      end
    end
    if (first) begin
      box_x_lo = sat_box((64'(sidx) + 64'd1) * 64'(spr_w));
      box_x_hi = sat_box(64'(sidx) * 64'(spr_w));
      box_y_lo = sat_box(64'(spr_h));
      box_y_hi = '0;
    end
    if (colour != clip_colour) begin
      if ({1'b0, px} < box_x_lo) box_x_lo = {1'b0, px};
      if ({1'b0, px} > box_x_hi) box_x_hi = {1'b0, px};
      if ({1'b0, py} < box_y_lo) box_y_lo = {1'b0, py};
      if ({1'b0, py} > box_y_hi) box_y_hi = {1'b0, py};
    end
    r.index = IW'(hit);
    r.size  = IW'(pal_count);
    r.done  = last;
    if (last) begin
      r.x_min = box_x_lo;
      r.x_max = box_x_hi;
      r.y_min = box_y_lo;
      r.y_max = box_y_hi;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d, %s: got 0x%0h, want 0x%0h",
                                n_results, name, got, want));
  endtask

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    if (!rst_n) begin
      clip_colour = '0;
      spr_w       = spbs_pkg::SPRITE_SIZE_RST;
      spr_h       = spbs_pkg::SPRITE_SIZE_RST;
      pal_count   = 0;
      box_x_lo    = '0;
      box_x_hi    = '0;
      box_y_lo    = '0;
      box_y_hi    = '0;
      foreach (palette[k]) palette[k] = '0;
      scan_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          spbs_pkg::CFG_CLIP_KEY:    clip_colour = cfg_data;
          spbs_pkg::CFG_CELL_WIDTH:  spr_w = cfg_data[spbs_pkg::SIZE_W-1:0];
          spbs_pkg::CFG_CELL_HEIGHT: spr_h = cfg_data[spbs_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{out_palette_index, out_color_is_new, out_palette_full, out_palette_size,
                out_sprite_done, out_box_x_min, out_box_x_max, out_box_y_min,
                out_box_y_max};
        if (scan_q.size() == 0) begin
          report_mismatch($sformatf("result with no pixel waiting, index 0x%0h",
                                    out_palette_index));
        end else begin
          want = scan_q.pop_front();
          check_field("palette_index", got.index, want.index);
          check_field("color_is_new", got.is_new, want.is_new);
          check_field("palette_full", got.full, want.full);
          check_field("palette_size", got.size, want.size);
          check_field("sprite_done", got.done, want.done);
          check_field("box_x_min", got.x_min, want.x_min);
          check_field("box_x_max", got.x_max, want.x_max);
          check_field("box_y_min", got.y_min, want.y_min);
          check_field("box_y_max", got.y_max, want.y_max);
          if (want.done) n_boxes++;
          if (want.full) n_dropped++;
        end
        n_results++;
      end
      if (in_valid && !in_stall) begin
        scan_q.push_back(scan_pixel(in_pixel_color, in_pos_x, in_pos_y, in_sprite_index,
                                    in_first_of_sprite, in_last_of_sprite, in_new_sheet));
        n_pixels++;
      end
    end
    pending = scan_q.size();
  end

endmodule

@@ dv/tb_sprite_palette_and_bbox_scanner_top.sv @@
`timescale 1ns / 1ps
// testbench top of the sprite palette and box scanner: stimulus, register settings and verdict
module tb_sprite_palette_and_bbox_scanner_top;

  localparam int PAL_DEPTH   = spbs_pkg::PALETTE_DEPTH_DEF;
  localparam int CW          = spbs_pkg::COORD_BITS_DEF;
  localparam int IW          = $clog2(PAL_DEPTH) + 1;
  // a request passes the entry register, each palette cell and the result register
  localparam int LATENCY     = PAL_DEPTH + 2;
  // long enough that the chain fills completely behind a stalled result
  localparam int HOLD_CYCLES = 3 * LATENCY;
  localparam int GAP_MAX     = 8;
  localparam int POOL_SIZE   = 16;
  // generous: the slowest legal run stays far below this
  localparam int LIMIT_NS    = 4_000_000;

  // register index beyond the three defined ones, must be ignored
  localparam logic [spbs_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  typedef struct {
    logic [spbs_pkg::COLOR_W-1:0] colour;
    logic [CW-1:0]                x;
    logic [CW-1:0]                y;
    logic [CW-1:0]                sidx;
    logic                         first;
    logic                         last;
    logic                         fresh;
  } pixel_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [spbs_pkg::COLOR_W-1:0]    in_pixel_color;
  logic [CW-1:0]                   in_pos_x;
  logic [CW-1:0]                   in_pos_y;
  logic [CW-1:0]                   in_sprite_index;
  logic                            in_first_of_sprite;
  logic                            in_last_of_sprite;
  logic                            in_new_sheet;
  logic                            out_valid;
  logic                            out_stall;
  logic [IW-1:0]                   out_palette_index;
  logic                            out_color_is_new;
  logic                            out_palette_full;
  logic [IW-1:0]                   out_palette_size;
  logic                            out_sprite_done;
  logic [CW:0]                     out_box_x_min;
  logic [CW:0]                     out_box_x_max;
  logic [CW:0]                     out_box_y_min;
  logic [CW:0]                     out_box_y_max;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [spbs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [spbs_pkg::CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int n_pixels;
  int n_boxes;
  int n_dropped;

  // stimulus-side view of the registers, used only to shape pixels
  logic [spbs_pkg::COLOR_W-1:0] cur_clip;
  int                           cur_w;
  int                           cur_h;
  logic [spbs_pkg::COLOR_W-1:0] colour_pool [POOL_SIZE];
  int                           items_sent = 0;
  int                           settings_applied = 0;
  // sender pacing: no_gaps forces back-to-back requests, send_burst is a random stretch
  bit                           no_gaps = 1'b0;
  bit                           send_burst = 1'b0;
  // bumped by the stimulus, served by the result sink as one long hold-off
  int                           hold_requests = 0;

  sprite_palette_and_bbox_scanner_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pixel_color     (in_pixel_color),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_sprite_index    (in_sprite_index),
    .in_first_of_sprite (in_first_of_sprite),
    .in_last_of_sprite  (in_last_of_sprite),
    .in_new_sheet       (in_new_sheet),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_palette_index  (out_palette_index),
    .out_color_is_new   (out_color_is_new),
    .out_palette_full   (out_palette_full),
    .out_palette_size   (out_palette_size),
    .out_sprite_done    (out_sprite_done),
    .out_box_x_min      (out_box_x_min),
    .out_box_x_max      (out_box_x_max),
    .out_box_y_min      (out_box_y_min),
    .out_box_y_max      (out_box_y_max),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  spbs_scan_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pixel_color     (in_pixel_color),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_sprite_index    (in_sprite_index),
    .in_first_of_sprite (in_first_of_sprite),
    .in_last_of_sprite  (in_last_of_sprite),
    .in_new_sheet       (in_new_sheet),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_palette_index  (out_palette_index),
    .out_color_is_new   (out_color_is_new),
    .out_palette_full   (out_palette_full),
    .out_palette_size   (out_palette_size),
    .out_sprite_done    (out_sprite_done),
    .out_box_x_min      (out_box_x_min),
    .out_box_x_max      (out_box_x_max),
    .out_box_y_min      (out_box_y_min),
    .out_box_y_max      (out_box_y_max),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending            (pending),
    .n_pixels           (n_pixels),
    .n_boxes            (n_boxes),
    .n_dropped          (n_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a request or a result never completes
  initial begin
    #(LIMIT_NS);
    $display("timeout: %0d pixels sent, %0d results still owed", items_sent, pending);
    $display("*** FAILED ***");
    $finish;
  end

  // one pixel request: random idle gap first, then hold the payload until accepted
  task automatic send_pixel(input pixel_t p);
    int gap;
    if (!no_gaps && $urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = (no_gaps || send_burst) ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid           <= 1'b1;
    in_pixel_color     <= p.colour;
    in_pos_x           <= p.x;
    in_pos_y           <= p.y;
    in_sprite_index    <= p.sidx;
    in_first_of_sprite <= p.first;
    in_last_of_sprite  <= p.last;
    in_new_sheet       <= p.fresh;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_px(input logic [31:0] colour, input int x, input int y, input int sidx,
                         input bit first, input bit last, input bit fresh);
    pixel_t p;
    p.colour = colour;
    p.x      = CW'(x);
    p.y      = CW'(y);
    p.sidx   = CW'(sidx);
    p.first  = first;
    p.last   = last;
    p.fresh  = fresh;
    send_pixel(p);
  endtask

  // drop valid and wait until every pixel sent so far has produced its result
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [spbs_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // registers only change with the block drained
  task automatic apply_setting(input logic [31:0] clip, input logic [31:0] w_data,
                               input logic [31:0] h_data);
    wait_idle();
    write_reg(spbs_pkg::CFG_CLIP_KEY, clip);
    write_reg(spbs_pkg::CFG_CELL_WIDTH, w_data);
    write_reg(spbs_pkg::CFG_CELL_HEIGHT, h_data);
    cur_clip = clip;
    cur_w    = int'(w_data & 32'h1FFF);
    cur_h    = int'(h_data & 32'h1FFF);
    settings_applied++;
  endtask

  // 45% repeats from a small pool so lookups hit, 15% clip pixels, the rest fresh colours;
  // fill mode is almost all fresh colours to drive the palette into overflow
  function automatic logic [31:0] pick_colour(input bit fill_mode);
    int r;
    r = $urandom_range(0, 99);
    if (fill_mode) return (r < 90) ? $urandom : colour_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 15) return cur_clip;
    if (r < 60) return colour_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // one sprite: first on the opening pixel, last on the closing one; one in ten
  // sprites gets scrambled flags to cover broken sequences
  task automatic send_sprite(input bit fill_mode);
    int      n;
    int      k;
    int      span_w;
    int      span_h;
    bit      fresh;
    bit      broken;
    longint  col;
    pixel_t  p;
    logic [CW-1:0] sidx;
    n      = $urandom_range(1, 10);
    sidx   = ($urandom_range(0, 9) == 0) ? CW'($urandom) : CW'($urandom_range(0, 15));
    fresh  = !fill_mode && ($urandom_range(0, 39) == 0);
    broken = ($urandom_range(0, 9) == 0);
    span_w = (cur_w > 0) ? cur_w - 1 : 0;
    span_h = (cur_h > 0) ? cur_h - 1 : 0;
    for (k = 0; k < n; k++) begin
      p.colour = pick_colour(fill_mode);
      if ($urandom_range(0, 3) == 0) begin
        // anywhere on the sheet, also outside the own cell
        p.x = CW'($urandom);
        p.y = CW'($urandom);
      end else begin
        col = longint'(sidx) * cur_w + $urandom_range(0, span_w);
        p.x = col[CW-1:0];
        p.y = CW'($urandom_range(0, span_h));
      end
      p.sidx = sidx;
      if (broken) begin
        p.first = 1'($urandom_range(0, 1));
        p.last  = 1'($urandom_range(0, 1));
        p.fresh = !fill_mode && ($urandom_range(0, 7) == 0);
      end else begin
        p.first = (k == 0);
        p.last  = (k == n - 1);
        p.fresh = (k == 0) && fresh;
      end
      send_pixel(p);
    end
  endtask

  task automatic run_sprites(input int count, input bit fill_mode);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) send_sprite(fill_mode);
  endtask

  // result sink: random wait per result, bursts with no stall, and on request one
  // long hold-off counted here so the chain fills and the input side stalls
  initial begin : result_sink
    int wait_n;
    int held;
    int holds_served;
    bit sink_burst;
    out_stall    = 1'b0;
    holds_served = 0;
    sink_burst   = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
      end
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      wait_n = sink_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    int k;
    // every input known from time zero
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_pixel_color     = '0;
    in_pos_x           = '0;
    in_pos_y           = '0;
    in_sprite_index    = '0;
    in_first_of_sprite = 1'b0;
    in_last_of_sprite  = 1'b0;
    in_new_sheet       = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    cur_clip           = '0;
    cur_w              = spbs_pkg::SPRITE_SIZE_RST;
    cur_h              = spbs_pkg::SPRITE_SIZE_RST;
    for (k = 0; k < POOL_SIZE; k++) colour_pool[k] = $urandom;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settings_applied = 1;

    // directed part on the reset settings: clip colour 0, cells of 16 by 16
    // no first pixel after reset, the box carries on from all zeros
    send_px(32'h1234_5678, 5, 7, 0, 1'b0, 1'b1, 1'b0);
    // sprite of clip pixels only on a fresh sheet reports the inverted start box
    send_px(32'h0000_0000, 3, 3, 1, 1'b1, 1'b1, 1'b1);
    // coordinate extremes, a palette hit and a clip pixel inside one sprite
    send_px(32'hFFFF_FFFF, 0, 0, 2, 1'b1, 1'b0, 1'b0);
    send_px(32'hFFFF_FFFF, 4095, 4095, 2, 1'b0, 1'b0, 1'b0);
    send_px(32'h0000_0000, 40, 9, 2, 1'b0, 1'b0, 1'b0);
    send_px(32'hA5A5_5A5A, 33, 2, 2, 1'b0, 1'b1, 1'b0);
    // highest sprite index, start values saturate at the box limit
    send_px(32'h0000_00FF, 4095, 0, 4095, 1'b1, 1'b1, 1'b0);
    send_px(32'h8000_0001, 0, 4095, 4095, 1'b1, 1'b0, 1'b1);
    // new sheet in the middle of a sprite, same colour lands at index 0 again
    send_px(32'h8000_0001, 17, 18, 4095, 1'b0, 1'b0, 1'b1);
    send_px(32'h7FFF_FFFE, 4094, 1, 4095, 1'b0, 1'b1, 1'b0);
    // first and last together, then a sprite left open and restarted
    send_px(32'h0F0F_0F0F, 20, 5, 1, 1'b1, 1'b1, 1'b0);
    send_px(32'hF0F0_F0F0, 31, 15, 1, 1'b1, 1'b0, 1'b0);
    send_px(32'h1234_5678, 16, 0, 1, 1'b1, 1'b1, 1'b0);
    run_sprites(220, 1'b0);

    // smallest cells and all-ones clip colour
    apply_setting(32'hFFFF_FFFF, 32'd1, 32'd1);
    send_px(32'hFFFF_FFFF, 7, 0, 7, 1'b1, 1'b1, 1'b0);
    run_sprites(220, 1'b0);

    // largest legal cells
    apply_setting($urandom, 32'd4096, 32'd4096);
    run_sprites(220, 1'b0);

    // zero width and height are used as written
    apply_setting(colour_pool[3], 32'd0, 32'd0);
    run_sprites(180, 1'b0);

    // upper data bits must be dropped: width becomes all ones, height 3;
    // the unused register index must leave everything alone
    apply_setting(colour_pool[5], 32'hFFFF_FFFF, 32'hFFFF_E003);
    write_reg(CFG_UNUSED_INDEX, $urandom);
    run_sprites(180, 1'b0);

    // back-pressure: sink holds off for a long stretch while pixels keep coming
    apply_setting(colour_pool[0], 32'd8, 32'd8);
    @(negedge clk);
    hold_requests <= hold_requests + 1;
    no_gaps = 1'b1;
    run_sprites(600, 1'b0);
    no_gaps = 1'b0;

    // mostly new colours and no new sheet, the palette overflows and drops colours
    apply_setting($urandom, 32'd16, 32'd16);
    run_sprites(450, 1'b1);

    // drain, then leave room for any stray result to show up
    wait_idle();
    repeat (LATENCY + 10) @(negedge clk);

    $display("run covered %0d pixels over %0d register settings, %0d sprite boxes reported",
             n_pixels, settings_applied, n_boxes);
    $display("palette overflow dropped %0d colours, one long result hold-off applied",
             n_dropped);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
